FILE: hw/rtl/csc_pkg.sv
// Shared types and constants for the sparse column assembly block.
// No dependencies; every module imports this package.
package csc_pkg;

    localparam int unsigned CmdW = 3;

    typedef enum logic [2:0] {
        CMD_BEGIN = 3'd0,
        CMD_NEIGH = 3'd1,
        CMD_ACCUM = 3'd2,
        CMD_READ  = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_OVF  = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [7:0]         row_index;
        logic [7:0]         col_index;
        logic signed [31:0] value;
        logic signed [31:0] scale;
    } t_req;

    typedef struct packed {
        logic signed [47:0] read_value;
        logic [1:0]         status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSTART,
        S_CWAIT,
        S_CHI,
        S_SCAN,
        S_SWAIT,
        S_SHIFT,
        S_SHWAIT,
        S_INSERT,
        S_MUL,
        S_ADD,
        S_WRITE,
        S_CLEAR,
        S_DONE
    } t_state;

    localparam logic signed [47:0] ValMax = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ValMin = {1'b1, {47{1'b0}}};

endpackage

FILE: hw/rtl/csc_mac.sv
// Shared multiply, round and saturating-add unit.
// Depends on csc_pkg. One registered multiply, then one add and clamp.
module csc_mac
    import csc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_mul_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic signed [47:0] i_acc,
    output logic signed [47:0] o_sum,
    output logic               o_sat
);
    logic signed [63:0] r_prod;
    logic signed [63:0] w_rnd;
    logic signed [49:0] w_q;
    logic signed [49:0] w_s;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // Round to Q.16, ties up; the rounded product fits in 49 bits.
    assign w_rnd = r_prod + 64'sd32768;
    assign w_q   = 50'(w_rnd >>> 16);
    assign w_s   = w_q + {{2{i_acc[47]}}, i_acc};

    always_comb begin
        o_sat = 1'b0;
        o_sum = w_s[47:0];
        if (w_s > $signed({{2{1'b0}}, ValMax})) begin
            o_sum = ValMax;
            o_sat = 1'b1;
        end else if (w_s < $signed({{2{1'b1}}, ValMin})) begin
            o_sum = ValMin;
            o_sat = 1'b1;
        end
    end
endmodule

FILE: hw/rtl/sparse_csc_assembly_top.sv
// Top level of the sparse column matrix assembly block.
// Depends on csc_pkg and csc_mac.
//
// Usage: requests arrive on i_req_valid/o_req_stall with payload i_req; one result per
// request leaves on o_rsp_valid/i_rsp_stall with payload o_rsp. The user must write
// symmetric_mode via i_cfg_we/i_cfg_data while the block is idle; it is not enforced.
//
// Each request is worked by a small sequencer over single-port entry memories
// (row and value), one entry access per cycle. Read and accumulate walk the
// column's rows; accumulate then multiplies, adds and writes the sum back.
// Add neighbor walks the column to find the slot and then moves every later
// entry up by one. Clear values sweeps all entries. Stall is high from
// acceptance until the result has been taken, so one request is in flight at
// a time. Reset (synchronous, active low) empties the structure and returns
// to idle. Entry values need no clearing pass: value words at or above the
// fill pointer are written zero when an entry is created, and below it every
// entry has been written. A stalled result holds in the output register.
module sparse_csc_assembly_top
    import csc_pkg::*;
#(
    parameter int unsigned MAX_COLS    = 256,
    parameter int unsigned MAX_ENTRIES = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp,
    input  logic i_cfg_we,
    input  logic i_cfg_data
);
    localparam int unsigned EW = $clog2(MAX_ENTRIES);
    localparam int unsigned PW = EW + 1;
    localparam int unsigned CW = $clog2(MAX_COLS + 1);
    localparam int unsigned AW = $clog2(MAX_COLS + 1);

    // Column start table and row/value stores.
    logic [PW-1:0] r_cstart [MAX_COLS+1];
    logic [7:0]    r_rowmem [MAX_ENTRIES];
    logic [47:0]   r_valmem [MAX_ENTRIES];
    logic [PW-1:0] r_cs_rd;
    logic [7:0]    r_row_rd;
    logic [47:0]   r_val_rd;

    t_state        r_state, n_state;
    logic          r_sym;
    logic [CW-1:0] r_ccount;
    logic [PW-1:0] r_fill;
    logic [7:0]    r_diag;
    t_req          r_req;
    logic [PW-1:0] r_ptr, r_hi, r_pos;
    logic          r_rsp_valid;
    t_rsp          r_rsp;

    // Memory control from the sequencer.
    logic          w_cs_re, w_cs_we;
    logic [AW-1:0] w_cs_ra, w_cs_wa;
    logic [PW-1:0] w_cs_wd;
    logic          w_m_re, w_m_we, w_row_we;
    logic [EW-1:0] w_m_ra, w_m_wa;
    logic [7:0]    w_row_wd;
    logic [47:0]   w_val_wd;

    logic               w_accept, w_done;
    logic signed [47:0] w_sum;
    logic               w_sat;
    logic               w_loc_ok;
    t_cmd               w_cmd;

    assign w_cmd       = t_cmd'(r_req.cmd);
    assign w_accept    = i_req_valid && !o_req_stall;
    assign o_req_stall = (r_state != S_IDLE) || r_rsp_valid;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Index and scale check for accumulate and read.
    assign w_loc_ok = (16'(r_req.row_index) < 16'(r_ccount))
        && (16'(r_req.col_index) < 16'(r_ccount))
        && !(r_sym && (r_req.row_index < r_req.col_index))
        && !((w_cmd == CMD_ACCUM) && (r_req.scale == 32'sd0));

    csc_mac u_mac (
        .i_clk    (i_clk),
        .i_mul_en (r_state == S_MUL),
        .i_a      (r_req.value),
        .i_b      (r_req.scale),
        .i_acc    (r_val_rd),
        .o_sum    (w_sum),
        .o_sat    (w_sat)
    );

    // Column 0 always starts at entry 0.
    always_ff @(posedge i_clk) begin
        if (w_cs_we) begin
            r_cstart[w_cs_wa] <= w_cs_wd;
        end
        if (w_cs_re) begin
            r_cs_rd <= (w_cs_ra == '0) ? '0 : r_cstart[w_cs_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_rowmem[w_m_wa] <= w_row_wd;
        end
        if (w_m_re) begin
            r_row_rd <= r_rowmem[w_m_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_we) begin
            r_valmem[w_m_wa] <= w_val_wd;
        end
        if (w_m_re) begin
            r_val_rd <= r_valmem[w_m_ra];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CSTART;
                end
            end
            S_CSTART: begin
                case (w_cmd)
                    CMD_BEGIN: n_state = S_DONE;
                    CMD_CLEAR: n_state = S_CLEAR;
                    CMD_NEIGH: begin
                        if (r_ccount == '0 || (r_sym && r_req.row_index <= r_diag)
                            || r_fill == PW'(MAX_ENTRIES)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_CWAIT;
                        end
                    end
                    CMD_ACCUM, CMD_READ: begin
                        n_state = w_loc_ok ? S_CWAIT : S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_CWAIT: n_state = (w_cmd == CMD_NEIGH) ? S_SCAN : S_CHI;
            S_CHI: n_state = S_SCAN;
            S_SCAN: begin
                if (r_ptr >= r_hi) begin
                    n_state = (w_cmd == CMD_NEIGH) ? S_SHIFT : S_DONE;
                end else begin
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (w_cmd == CMD_NEIGH) begin
                    n_state = (r_row_rd > r_req.row_index) ? S_SHIFT : S_SCAN;
                end else if (r_row_rd == r_req.row_index) begin
                    n_state = (w_cmd == CMD_ACCUM) ? S_MUL : S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SHIFT: n_state = (r_ptr > r_pos) ? S_SHWAIT : S_INSERT;
            S_SHWAIT: n_state = S_SHIFT;
            S_INSERT: n_state = S_DONE;
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_CLEAR: n_state = (r_ptr == PW'(MAX_ENTRIES - 1)) ? S_DONE : S_CLEAR;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory control outputs.
    always_comb begin
        w_cs_re  = 1'b0;
        w_cs_ra  = '0;
        w_cs_we  = 1'b0;
        w_cs_wa  = '0;
        w_cs_wd  = '0;
        w_m_re   = 1'b0;
        w_m_ra   = r_ptr[EW-1:0];
        w_m_we   = 1'b0;
        w_row_we = 1'b0;
        w_m_wa   = r_ptr[EW-1:0];
        w_row_wd = r_row_rd;
        w_val_wd = r_val_rd;
        case (r_state)
            S_CSTART: begin
                w_cs_re = 1'b1;
                if (w_cmd == CMD_NEIGH) begin
                    w_cs_ra = AW'(r_ccount - 1'b1);
                end else begin
                    w_cs_ra = AW'(r_req.col_index);
                end
            end
            S_CWAIT: begin
                // Fetch the end of the column for accumulate and read.
                if (w_cmd != CMD_NEIGH) begin
                    w_cs_re = 1'b1;
                    w_cs_ra = AW'(r_req.col_index) + 1'b1;
                end
            end
            S_SCAN: begin
                w_m_re = (r_ptr < r_hi);
            end
            S_SHIFT: begin
                w_m_re = (r_ptr > r_pos);
                w_m_ra = EW'(r_ptr - 1'b1);
            end
            S_SHWAIT: begin
                w_m_we   = 1'b1;
                w_row_we = 1'b1;
            end
            S_INSERT: begin
                w_m_we   = 1'b1;
                w_row_we = 1'b1;
                w_m_wa   = r_pos[EW-1:0];
                w_row_wd = r_req.row_index;
                w_val_wd = '0;
                w_cs_we  = 1'b1;
                w_cs_wa  = AW'(r_ccount);
                w_cs_wd  = r_fill + 1'b1;
            end
            S_WRITE: begin
                w_m_we   = 1'b1;
                w_m_wa   = r_pos[EW-1:0];
                w_val_wd = r_rsp.read_value;
            end
            S_CLEAR: begin
                w_m_we   = 1'b1;
                w_val_wd = '0;
            end
            S_DONE: begin
                // Begin column: create the diagonal entry.
                if (w_cmd == CMD_BEGIN && r_rsp.status == ST_OK) begin
                    w_m_we   = 1'b1;
                    w_row_we = 1'b1;
                    w_m_wa   = r_fill[EW-1:0];
                    w_row_wd = r_req.row_index;
                    w_val_wd = '0;
                    w_cs_we  = 1'b1;
                    w_cs_wa  = AW'(r_ccount + 1'b1);
                    w_cs_wd  = r_fill + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign w_done = (r_state == S_DONE);

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sym       <= 1'b0;
            r_ccount    <= '0;
            r_fill      <= '0;
            r_diag      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_sym <= i_cfg_data;
            end
            if (r_rsp_valid && !i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            if (w_done) begin
                r_rsp_valid <= 1'b1;
                if (w_cmd == CMD_BEGIN && r_rsp.status == ST_OK) begin
                    r_ccount <= r_ccount + 1'b1;
                    r_fill   <= r_fill + 1'b1;
                    r_diag   <= r_req.row_index;
                end
            end
            if (r_state == S_INSERT) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        case (r_state)
            S_CSTART: begin
                r_rsp.read_value <= '0;
                r_rsp.status     <= ST_MISS;
                r_ptr            <= '0;
                if (w_cmd == CMD_BEGIN) begin
                    if (r_ccount >= CW'(MAX_COLS) || r_fill == PW'(MAX_ENTRIES)) begin
                        r_rsp.status <= ST_OVF;
                    end else begin
                        r_rsp.status <= ST_OK;
                    end
                end else if (w_cmd == CMD_CLEAR) begin
                    r_rsp.status <= ST_OK;
                end else if (w_cmd == CMD_NEIGH && r_ccount != '0
                             && !(r_sym && r_req.row_index <= r_diag)
                             && r_fill == PW'(MAX_ENTRIES)) begin
                    r_rsp.status <= ST_OVF;
                end
            end
            S_CWAIT: begin
                r_ptr <= r_cs_rd;
                if (w_cmd == CMD_NEIGH) begin
                    r_hi  <= r_fill;
                    r_pos <= r_fill;
                end
            end
            S_CHI: begin
                r_hi <= r_cs_rd;
            end
            S_SCAN: begin
                if (r_ptr >= r_hi && w_cmd == CMD_NEIGH) begin
                    r_ptr <= r_fill;
                end
            end
            S_SWAIT: begin
                if (w_cmd == CMD_NEIGH && r_row_rd > r_req.row_index) begin
                    r_pos <= r_ptr;
                    r_ptr <= r_fill;
                end else if (w_cmd != CMD_NEIGH && r_row_rd == r_req.row_index) begin
                    r_pos <= r_ptr;
                    r_rsp.status <= ST_OK;
                    if (w_cmd == CMD_READ) begin
                        r_rsp.read_value <= r_val_rd;
                    end
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            S_SHWAIT: begin
                r_ptr <= r_ptr - 1'b1;
            end
            S_INSERT: begin
                r_rsp.status <= ST_OK;
            end
            S_ADD: begin
                r_rsp.read_value <= w_sum;
                r_rsp.status     <= w_sat ? ST_SAT : ST_OK;
            end
            S_WRITE: begin
                r_rsp.read_value <= '0;
            end
            S_CLEAR: begin
                r_ptr <= r_ptr + 1'b1;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_req_stall)
        else $error("request accepted while a result is pending");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= PW'(MAX_ENTRIES))
        else $error("fill pointer beyond capacity");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> o_rsp_valid)
        else $error("finished request produced no result");
`endif
endmodule
